FILE: src/pd3d_pkg.sv
// Shared types and constants of the periodic 3D divergence block.
package pd3d_pkg;

    localparam int COORD_W = 4;
    localparam int SIZE_W  = 5;
    localparam int WORD_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP_Z = 3'd5;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
        logic [WORD_W-1:0] recip_x;
        logic [WORD_W-1:0] recip_y;
        logic [WORD_W-1:0] recip_z;
    } cfg_t;

    typedef struct packed {
        logic                     is_query;
        logic                     bad;
        logic [COORD_W-1:0]       x;
        logic [COORD_W-1:0]       y;
        logic [COORD_W-1:0]       z;
        logic [SIZE_W-1:0]        px;
        logic [SIZE_W-1:0]        py;
        logic [SIZE_W-1:0]        pz;
        logic signed [WORD_W-1:0] comp_x;
        logic signed [WORD_W-1:0] comp_y;
        logic signed [WORD_W-1:0] comp_z;
    } cmd_t;

endpackage

FILE: src/pd3d_front.sv
// Front end: accepts words, checks coordinates, finds wrapped neighbours, queues commands.
module pd3d_front #(
    parameter int MAX_NX = 16,
    parameter int MAX_NY = 16,
    parameter int MAX_NZ = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pd3d_pkg::cfg_t                      cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pd3d_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    output logic                                q_valid,
    input  logic                                q_ready,
    output pd3d_pkg::cmd_t                      q_data
);

    function automatic logic [pd3d_pkg::SIZE_W-1:0] eff_size(
        input logic [pd3d_pkg::SIZE_W-1:0] s,
        input int                          max_n
    );
        return (int'(s) > max_n) ? pd3d_pkg::SIZE_W'(max_n) : s;
    endfunction

    logic [pd3d_pkg::SIZE_W-1:0] nx, ny, nz;
    logic [pd3d_pkg::COORD_W-1:0] cx, cy, cz;
    pd3d_pkg::cmd_t cmd;

    pd3d_pkg::cmd_t ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign nx = eff_size(cfg.size_x, MAX_NX);
    assign ny = eff_size(cfg.size_y, MAX_NY);
    assign nz = eff_size(cfg.size_z, MAX_NZ);
    assign cx = s_tdata[3:0];
    assign cy = s_tdata[7:4];
    assign cz = s_tdata[11:8];

    always_comb begin
        cmd.is_query = s_tuser;
        cmd.bad = ({1'b0, cx} >= nx) || ({1'b0, cy} >= ny) || ({1'b0, cz} >= nz);
        cmd.x = cx;
        cmd.y = cy;
        cmd.z = cz;
        cmd.px = (cx == '0) ? nx - 5'd1 : {1'b0, cx} - 5'd1;
        cmd.py = (cy == '0) ? ny - 5'd1 : {1'b0, cy} - 5'd1;
        cmd.pz = (cz == '0) ? nz - 5'd1 : {1'b0, cz} - 5'd1;
        cmd.comp_x = $signed(s_tdata[43:12]);
        cmd.comp_y = $signed(s_tdata[75:44]);
        cmd.comp_z = $signed(s_tdata[107:76]);
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = ent_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

FILE: src/pd3d_back.sv
// Back end: field stores, difference, scaling, saturating sum and output register.
module pd3d_back #(
    parameter int MAX_NX = 16,
    parameter int MAX_NY = 16,
    parameter int MAX_NZ = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pd3d_pkg::cfg_t                 cfg,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  pd3d_pkg::cmd_t                 q_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pd3d_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                     m_tuser
);

    localparam int DEPTH  = MAX_NX * MAX_NY * MAX_NZ;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_TERM = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;

    function automatic logic [ADDR_W-1:0] addr_of(
        input logic [pd3d_pkg::SIZE_W-1:0] ax,
        input logic [pd3d_pkg::SIZE_W-1:0] ay,
        input logic [pd3d_pkg::SIZE_W-1:0] az
    );
        return ADDR_W'((ADDR_W'(ax) * ADDR_W'(MAX_NY) + ADDR_W'(ay)) * ADDR_W'(MAX_NZ)
                       + ADDR_W'(az));
    endfunction

    logic [31:0] mem_x [DEPTH];
    logic [31:0] mem_y [DEPTH];
    logic [31:0] mem_z [DEPTH];

    logic [2:0] state_reg, state_next;
    logic       pop, load_out;
    logic [pd3d_pkg::SIZE_W-1:0] qx, qy, qz;
    logic [ADDR_W-1:0] a_c, a_px, a_py, a_pz;
    logic [31:0] recip [3];

    logic [31:0] here_reg [3];
    logic [31:0] prev_reg [3];
    logic        bad_reg;
    logic        neg_reg  [3];
    logic [32:0] mag_reg  [3];
    logic        hi_reg   [3];
    logic [63:0] prod_reg [3];
    logic [48:0] term_reg [3];

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_div_reg;
    logic        out_clip_reg;
    logic        out_bad_reg;

    logic [50:0] sum;
    logic        sum_clip;
    logic [31:0] sum_sat;

    assign recip[0] = cfg.recip_x;
    assign recip[1] = cfg.recip_y;
    assign recip[2] = cfg.recip_z;

    assign q_ready = (state_reg == ST_IDLE);
    assign pop     = q_valid && q_ready;

    assign qx   = {1'b0, q_data.x};
    assign qy   = {1'b0, q_data.y};
    assign qz   = {1'b0, q_data.z};
    assign a_c  = addr_of(qx, qy, qz);
    assign a_px = addr_of(q_data.px, qy, qz);
    assign a_py = addr_of(qx, q_data.py, qz);
    assign a_pz = addr_of(qx, qy, q_data.pz);

    always_ff @(posedge aclk) begin
        if (pop && (q_data.is_query == pd3d_pkg::REQ_WRITE) && !q_data.bad) begin
            mem_x[a_c] <= q_data.comp_x;
            mem_y[a_c] <= q_data.comp_y;
            mem_z[a_c] <= q_data.comp_z;
        end
        if (pop && (q_data.is_query == pd3d_pkg::REQ_QUERY)) begin
            here_reg[0] <= mem_x[a_c];
            prev_reg[0] <= mem_x[a_px];
            here_reg[1] <= mem_y[a_c];
            prev_reg[1] <= mem_y[a_py];
            here_reg[2] <= mem_z[a_c];
            prev_reg[2] <= mem_z[a_pz];
            bad_reg     <= q_data.bad;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (state_reg == ST_DIFF) begin
                logic signed [32:0] d;
                d = $signed({here_reg[i][31], here_reg[i]})
                  - $signed({prev_reg[i][31], prev_reg[i]});
                neg_reg[i] <= d[32];
                mag_reg[i] <= d[32] ? 33'(-d) : 33'(d);
            end
            if (state_reg == ST_MUL) begin
                prod_reg[i] <= 64'(mag_reg[i][31:0]) * 64'(recip[i]);
                hi_reg[i]   <= mag_reg[i][32];
            end
            if (state_reg == ST_TERM) begin
                logic [63:0] full;
                logic [64:0] sgn;
                full = prod_reg[i] + (hi_reg[i] ? {recip[i], 32'd0} : 64'd0);
                sgn  = neg_reg[i] ? -{1'b0, full} : {1'b0, full};
                term_reg[i] <= sgn[64:16];
            end
        end
    end

    always_comb begin
        sum = {{2{term_reg[0][48]}}, term_reg[0]}
            + {{2{term_reg[1][48]}}, term_reg[1]}
            + {{2{term_reg[2][48]}}, term_reg[2]};
        sum_clip = !((&sum[50:31]) || !(|sum[50:31]));
        if (sum_clip) begin
            sum_sat = sum[50] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sum_sat = sum[31:0];
        end
    end

    assign load_out = (state_reg == ST_SUM) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop && (q_data.is_query == pd3d_pkg::REQ_QUERY)) begin
                    state_next = q_data.bad ? ST_SUM : ST_DIFF;
                end
            end
            ST_DIFF: state_next = ST_MUL;
            ST_MUL:  state_next = ST_TERM;
            ST_TERM: state_next = ST_SUM;
            ST_SUM: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_div_reg  <= bad_reg ? 32'd0 : sum_sat;
            out_clip_reg <= bad_reg ? 1'b0 : sum_clip;
            out_bad_reg  <= bad_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_div_reg;
    assign m_tuser  = {out_bad_reg, out_clip_reg};

`ifndef SYNTHESIS
    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_bad_reg |-> (out_div_reg == 32'd0) && !out_clip_reg)
        else $error("bad coordinate result carries a value");

    a_clip_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_clip_reg |->
            (out_div_reg == 32'h7FFF_FFFF) || (out_div_reg == 32'h8000_0000))
        else $error("clipped result is not a saturation bound");

    a_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && (q_data.is_query == pd3d_pkg::REQ_QUERY) |=>
            (state_reg == ST_DIFF) || (state_reg == ST_SUM))
        else $error("query did not start the datapath");

    a_write_done: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && (q_data.is_query == pd3d_pkg::REQ_WRITE) |=> (state_reg == ST_IDLE))
        else $error("write left the back end busy");
`endif

endmodule

FILE: src/periodic_divergence_3d_top.sv
// Top level of the periodic 3D divergence block: configuration registers and the two halves.
//
// Stores a 3-component Q16.16 vector field per grid point and answers divergence queries
// using backward differences with periodic wrap. A write word is stored as it is taken, and
// the back end stays idle. A query goes through store read, difference, multiply, scale and
// saturating sum before its result enters the output register. A query with a bad
// coordinate skips the difference, multiply and scale steps. A two-entry command queue
// sits in front, so words are accepted while the back end works or a result waits to be
// taken. The field stores hold no defined value until written and need no clearing after
// reset. Configuration is written through the cfg channel, which is always ready.
module periodic_divergence_3d_top #(
    parameter int MAX_NX = 16,
    parameter int MAX_NY = 16,
    parameter int MAX_NZ = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pd3d_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pd3d_pkg::WORD_W-1:0]         cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // coord_x[3:0], coord_y[7:4], coord_z[11:8], comp_x[43:12], comp_y[75:44],
    // comp_z[107:76], zero pad[111:108]
    input  logic [pd3d_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // div_value[31:0]
    output logic [pd3d_pkg::M_TDATA_W-1:0]      m_tdata,
    // clipped[0], bad_coord[1]
    output logic [1:0]                          m_tuser
);

    pd3d_pkg::cfg_t cfg_reg, cfg_next;
    logic           q_valid, q_ready;
    pd3d_pkg::cmd_t q_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pd3d_pkg::CFG_SIZE_X:  cfg_next.size_x  = cfg_data[4:0];
                pd3d_pkg::CFG_SIZE_Y:  cfg_next.size_y  = cfg_data[4:0];
                pd3d_pkg::CFG_SIZE_Z:  cfg_next.size_z  = cfg_data[4:0];
                pd3d_pkg::CFG_RECIP_X: cfg_next.recip_x = cfg_data;
                pd3d_pkg::CFG_RECIP_Y: cfg_next.recip_y = cfg_data;
                pd3d_pkg::CFG_RECIP_Z: cfg_next.recip_z = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.size_x  <= 5'd16;
            cfg_reg.size_y  <= 5'd16;
            cfg_reg.size_z  <= 5'd16;
            cfg_reg.recip_x <= 32'd65536;
            cfg_reg.recip_y <= 32'd65536;
            cfg_reg.recip_z <= 32'd65536;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pd3d_front #(
        .MAX_NX(MAX_NX),
        .MAX_NY(MAX_NY),
        .MAX_NZ(MAX_NZ)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    pd3d_back #(
        .MAX_NX(MAX_NX),
        .MAX_NY(MAX_NY),
        .MAX_NZ(MAX_NZ)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

FILE: tb/pd3d_tb_pkg.sv
// Scoreboard of the periodic 3D divergence testbench: field mirror, divergence predictor, checker.
package pd3d_tb_pkg;

    import pd3d_pkg::*;

    localparam int GRID_N      = 16;
    localparam int GRID_POINTS = GRID_N * GRID_N * GRID_N;

    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [WORD_W-1:0]  cx;
        logic [WORD_W-1:0]  cy;
        logic [WORD_W-1:0]  cz;
    } field_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] div_value;
        logic              clipped;
        logic              bad_coord;
    } div_word_t;

    class divergence_checker;
        logic [SIZE_W-1:0] size_x, size_y, size_z;
        logic [WORD_W-1:0] recip_x, recip_y, recip_z;
        logic [WORD_W-1:0] field_x [GRID_POINTS];
        logic [WORD_W-1:0] field_y [GRID_POINTS];
        logic [WORD_W-1:0] field_z [GRID_POINTS];
        bit                written [GRID_POINTS];
        div_word_t         pending_divs [$];
        int                errors, n_writes, n_queries, n_bad, n_clipped;

        function new();
            size_x = 5'd16;
            size_y = 5'd16;
            size_z = 5'd16;
            recip_x = 32'h0001_0000;
            recip_y = 32'h0001_0000;
            recip_z = 32'h0001_0000;
            errors = 0;
            n_writes = 0;
            n_queries = 0;
            n_bad = 0;
            n_clipped = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            case (idx)
                CFG_SIZE_X:  size_x = data[SIZE_W-1:0];
                CFG_SIZE_Y:  size_y = data[SIZE_W-1:0];
                CFG_SIZE_Z:  size_z = data[SIZE_W-1:0];
                CFG_RECIP_X: recip_x = data;
                CFG_RECIP_Y: recip_y = data;
                CFG_RECIP_Z: recip_z = data;
                default: ;
            endcase
        endfunction

        function int span(logic [SIZE_W-1:0] s);
            return (s > GRID_N) ? GRID_N : int'(s);
        endfunction

        function int grid_addr(int x, int y, int z);
            return (x * GRID_N + y) * GRID_N + z;
        endfunction

        function int wrap_prev(int c, int n);
            return (c == 0) ? n - 1 : c - 1;
        endfunction

        function bit out_of_grid(int x, int y, int z);
            return x >= span(size_x) || y >= span(size_y) || z >= span(size_z);
        endfunction

        // point itself, then its backward neighbor along x, y and z
        function void query_taps(int x, int y, int z, output int taps [4]);
            taps[0] = grid_addr(x, y, z);
            taps[1] = grid_addr(wrap_prev(x, span(size_x)), y, z);
            taps[2] = grid_addr(x, wrap_prev(y, span(size_y)), z);
            taps[3] = grid_addr(x, y, wrap_prev(z, span(size_z)));
        endfunction

        // floor((here - prev) * recip / 2^16)
        function logic signed [48:0] scaled_term(logic [WORD_W-1:0] here,
                                                  logic [WORD_W-1:0] prev,
                                                  logic [WORD_W-1:0] recip);
            logic signed [32:0] d;
            logic signed [65:0] p;
            d = $signed({here[31], here}) - $signed({prev[31], prev});
            p = d * $signed({1'b0, recip});
            return p >>> 16;
        endfunction

        function void note_word(field_word_t w);
            div_word_t          r;
            int                 taps [4];
            int                 a;
            logic signed [50:0] sum;
            if (w.req_type == REQ_WRITE) begin
                n_writes++;
                if (!out_of_grid(w.x, w.y, w.z)) begin
                    a = grid_addr(w.x, w.y, w.z);
                    field_x[a] = w.cx;
                    field_y[a] = w.cy;
                    field_z[a] = w.cz;
                    written[a] = 1'b1;
                end
                return;
            end
            n_queries++;
            r = '0;
            if (out_of_grid(w.x, w.y, w.z)) begin
                r.bad_coord = 1'b1;
                n_bad++;
            end else begin
                query_taps(w.x, w.y, w.z, taps);
                sum = scaled_term(field_x[taps[0]], field_x[taps[1]], recip_x)
                    + scaled_term(field_y[taps[0]], field_y[taps[2]], recip_y)
                    + scaled_term(field_z[taps[0]], field_z[taps[3]], recip_z);
                if (sum > 51'sh7FFF_FFFF) begin
                    r.div_value = 32'h7FFF_FFFF;
                    r.clipped = 1'b1;
                end else if (sum < -51'sh8000_0000) begin
                    r.div_value = 32'h8000_0000;
                    r.clipped = 1'b1;
                end else begin
                    r.div_value = sum[31:0];
                end
                if (r.clipped) begin
                    n_clipped++;
                end
            end
            pending_divs.insert(pending_divs.size(), r);
        endfunction

        function void check_word(logic [WORD_W-1:0] data, logic [1:0] user, longint unsigned now);
            div_word_t got;
            div_word_t want;
            got.div_value = data;
            got.clipped   = user[0];
            got.bad_coord = user[1];
            if (pending_divs.size() == 0) begin
                errors++;
                $display("%0d ns: unexpected result: div_value %h clipped %b bad_coord %b",
                         now, got.div_value, got.clipped, got.bad_coord);
                return;
            end
            want = pending_divs.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0d ns: mismatch: expected div_value %h clipped %b bad_coord %b",
                         now, want.div_value, want.clipped, want.bad_coord);
                $display("%0d ns:           actual div_value %h clipped %b bad_coord %b",
                         now, got.div_value, got.clipped, got.bad_coord);
            end
        endfunction
    endclass

endpackage

FILE: tb/tb_periodic_divergence_3d_top.sv
// Testbench top of the periodic 3D divergence block: clock, reset, stimulus and result monitor.
module tb_periodic_divergence_3d_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pd3d_pkg::*;
    import pd3d_tb_pkg::*;

    localparam int          RANDOM_ITEMS = 1300;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          CYCLE_LIMIT  = 750000;
    localparam logic [31:0] COMP_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] COMP_MIN     = 32'h8000_0000;
    localparam logic [31:0] RECIP_ONE    = 32'h0001_0000;
    localparam logic [31:0] RECIP_MAX    = 32'hFFFF_FFFF;

    typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_BLOCKED} rx_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [WORD_W-1:0]      cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [1:0]             m_tuser;

    divergence_checker chk;
    int                cycle_count = 0;
    int                burst_left = 0;
    int                settings = 0;
    int                mode_left = 0;
    int                stall_left = 0;
    rx_mode_t          rx_mode = RX_OPEN;

    periodic_divergence_3d_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            chk.check_word(m_tdata, m_tuser, $time);
        end
    end

    always @(negedge aclk) begin
        if (mode_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 256);
        end
        mode_left--;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_left == 0) begin
                    stall_left = $urandom_range(4, 30);
                    m_tready <= 1'b1;
                end else begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
            end
        endcase
    end

    function automatic logic [31:0] rand_comp();
        int v;
        v = $urandom_range(0, 262143) - 131072;
        case ($urandom_range(0, 7))
            0:       return COMP_MAX;
            1:       return COMP_MIN;
            2, 3:    return v;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_recip();
        case ($urandom_range(0, 7))
            0:       return RECIP_ONE;
            1:       return RECIP_MAX;
            2:       return 32'd0;
            3:       return 32'd1;
            4, 5:    return $urandom_range(1, 32'h0004_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [4:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return 5'($urandom_range(17, 31));
            default: return 5'($urandom_range(2, 6));
        endcase
    endfunction

    task automatic send_word(field_word_t w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= w.req_type;
        s_tdata  <= {4'b0000, w.cz, w.cy, w.cx, w.z, w.y, w.x};
        do @(posedge aclk); while (!s_tready);
        chk.note_word(w);
    endtask

    task automatic put_write(int x, int y, int z, logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cz);
        field_word_t w;
        w.req_type = REQ_WRITE;
        w.x = 4'(x);
        w.y = 4'(y);
        w.z = 4'(z);
        w.cx = cx;
        w.cy = cy;
        w.cz = cz;
        send_word(w);
    endtask

    // any tap not yet stored gets a write first, so a query never reads an empty entry
    task automatic put_query(int x, int y, int z);
        field_word_t w;
        int          taps [4];
        if (!chk.out_of_grid(x, y, z)) begin
            chk.query_taps(x, y, z, taps);
            foreach (taps[i]) begin
                if (!chk.written[taps[i]]) begin
                    put_write(taps[i] / (GRID_N * GRID_N), (taps[i] / GRID_N) % GRID_N,
                              taps[i] % GRID_N, rand_comp(), rand_comp(), rand_comp());
                end
            end
        end
        w.req_type = REQ_QUERY;
        w.x = 4'(x);
        w.y = 4'(y);
        w.z = 4'(z);
        w.cx = $urandom();
        w.cy = $urandom();
        w.cz = $urandom();
        send_word(w);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (chk.pending_divs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        chk.set_reg(idx, data);
    endtask

    task automatic configure(logic [4:0] sx, logic [4:0] sy, logic [4:0] sz,
                             logic [31:0] rx, logic [31:0] ry, logic [31:0] rz, bit junk);
        logic [26:0] hi;
        hi = junk ? 27'($urandom()) : '0;
        wait_idle();
        write_reg(CFG_SIZE_X, {hi, sx});
        write_reg(CFG_SIZE_Y, {hi, sy});
        write_reg(CFG_SIZE_Z, {hi, sz});
        write_reg(CFG_RECIP_X, rx);
        write_reg(CFG_RECIP_Y, ry);
        write_reg(CFG_RECIP_Z, rz);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // mostly in-grid writes and queries; some words anywhere in the coordinate range
    task automatic random_word();
        int nx, ny, nz, x, y, z;
        bit anywhere, is_write;
        nx = chk.span(chk.size_x);
        ny = chk.span(chk.size_y);
        nz = chk.span(chk.size_z);
        anywhere = ($urandom_range(0, 99) < 12) || nx == 0 || ny == 0 || nz == 0;
        is_write = ($urandom_range(0, 99) < 45);
        x = anywhere ? $urandom_range(0, GRID_N - 1) : $urandom_range(0, nx - 1);
        y = anywhere ? $urandom_range(0, GRID_N - 1) : $urandom_range(0, ny - 1);
        z = anywhere ? $urandom_range(0, GRID_N - 1) : $urandom_range(0, nz - 1);
        if (is_write) begin
            put_write(x, y, z, rand_comp(), rand_comp(), rand_comp());
        end else begin
            put_query(x, y, z);
        end
    endtask

    initial begin
        int phase_len;
        chk = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // full grid, unit spacing: saturation both ways and the wrap at both ends
        configure(5'd16, 5'd16, 5'd16, RECIP_ONE, RECIP_ONE, RECIP_ONE, 1'b0);
        put_write(0, 0, 0, COMP_MAX, COMP_MAX, COMP_MAX);
        put_write(15, 0, 0, COMP_MIN, COMP_MIN, COMP_MIN);
        put_write(0, 15, 0, COMP_MIN, COMP_MIN, COMP_MIN);
        put_write(0, 0, 15, COMP_MIN, COMP_MIN, COMP_MIN);
        put_query(0, 0, 0);
        put_write(1, 0, 0, COMP_MIN, COMP_MIN, COMP_MIN);
        put_write(1, 15, 0, COMP_MAX, COMP_MAX, COMP_MAX);
        put_write(1, 0, 15, COMP_MAX, COMP_MAX, COMP_MAX);
        put_query(1, 0, 0);
        put_write(15, 15, 15, RECIP_ONE, RECIP_ONE, RECIP_ONE);
        put_query(15, 15, 15);

        // one-point axes with largest spacing reciprocal; out-of-grid write and queries
        configure(5'd1, 5'd1, 5'd1, RECIP_MAX, RECIP_MAX, RECIP_MAX, 1'b0);
        put_write(0, 0, 0, rand_comp(), rand_comp(), rand_comp());
        put_query(0, 0, 0);
        put_write(1, 0, 0, rand_comp(), rand_comp(), rand_comp());
        put_query(0, 0, 1);
        put_query(15, 15, 15);

        // empty x axis: nothing is in the grid
        configure(5'd0, 5'd16, 5'd16, 32'd0, 32'd0, 32'd0, 1'b0);
        put_query(0, 0, 0);
        put_write(0, 3, 3, rand_comp(), rand_comp(), rand_comp());
        put_query(5, 15, 15);

        // sizes past the maximum, zero x spacing reciprocal
        configure(5'd31, 5'd17, 5'd20, 32'd0, 32'h0000_8000, RECIP_MAX, 1'b0);
        put_query(0, 0, 0);
        put_query(15, 15, 15);
        put_write(3, 4, 5, rand_comp(), rand_comp(), rand_comp());
        put_query(3, 4, 5);

        while (chk.n_writes + chk.n_queries < RANDOM_ITEMS) begin
            configure(rand_size(), rand_size(), rand_size(),
                      rand_recip(), rand_recip(), rand_recip(), 1'($urandom_range(0, 1)));
            phase_len = $urandom_range(60, 160);
            for (int i = 0; i < phase_len && chk.n_writes + chk.n_queries < RANDOM_ITEMS;
                 i++) begin
                random_word();
            end
        end

        wait_idle();
        $display("Covered %0d writes and %0d queries (%0d out of grid, %0d saturated)",
                 chk.n_writes, chk.n_queries, chk.n_bad, chk.n_clipped);
        $display("over %0d register settings in %0d cycles.", settings, cycle_count);
        if (chk.errors == 0 && chk.pending_divs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/pd3d_pkg.sv
src/pd3d_front.sv
src/pd3d_back.sv
src/periodic_divergence_3d_top.sv
tb/pd3d_tb_pkg.sv
tb/tb_periodic_divergence_3d_top.sv
